@@ rtl/lpfr_pkg.sv @@
// Shared types, constants and helper functions for the laser point frame renderer.
// No dependencies; used by lpfr_ctrl, lpfr_dpath and the top level.
`timescale 1ns / 1ps

package lpfr_pkg;

  localparam int MAX_POINTS  = 4096;
  localparam int FRAME_SLOTS = 3;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int SLOT_W      = 2;
  localparam int ADDR_W      = SLOT_W + IDX_W;
  localparam int STORE_DEPTH = FRAME_SLOTS * MAX_POINTS;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // DAC command nibbles above the 12-bit code
  localparam logic [3:0] DAC_CMD_A = 4'b1101;
  localparam logic [3:0] DAC_CMD_B = 4'b0101;

  localparam int BLANK_BIT = 6;

  localparam logic [2:0] RGB_OFF   = 3'b000;
  localparam logic [2:0] RGB_R     = 3'b001;
  localparam logic [2:0] RGB_RG    = 3'b011;
  localparam logic [2:0] RGB_G     = 3'b010;
  localparam logic [2:0] RGB_GB    = 3'b110;
  localparam logic [2:0] RGB_B     = 3'b100;
  localparam logic [2:0] RGB_BR    = 3'b101;
  localparam logic [2:0] RGB_WHITE = 3'b111;

  localparam logic [7:0] BAND_R_MAX  = 8'd9;
  localparam logic [7:0] BAND_RG_MAX = 8'd18;
  localparam logic [7:0] BAND_G_MAX  = 8'd27;
  localparam logic [7:0] BAND_GB_MAX = 8'd36;
  localparam logic [7:0] BAND_B_MAX  = 8'd45;
  localparam logic [7:0] BAND_BR_MAX = 8'd54;
  localparam logic [7:0] COLOUR_MAX  = 8'd63;

  localparam logic [11:0] DAC_MID = 12'd2048;

  typedef struct packed {
    logic                    operation;
    logic [IDX_W-1:0]        point_index;
    logic signed [15:0]      pos_x;
    logic signed [15:0]      pos_y;
    logic [7:0]              colour_index;
    logic [7:0]              status_bits;
    logic [CNT_W-1:0]        frame_points;
  } item_t;

  typedef struct packed {
    logic                    point_valid;
    logic [15:0]             dac_word_a;
    logic [15:0]             dac_word_b;
    logic [2:0]              laser_rgb;
    logic [SLOT_W-1:0]       read_slot_out;
  } result_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         colour;
    logic [7:0]         status;
  } point_t;

  typedef struct packed {
    logic wr;      // store point, update write bookkeeping
    logic rd;      // start point read for a tick
    logic finish;  // frame done: rewind and post result
    logic emit;    // read data ready: post point result
  } cmd_t;

  typedef struct packed {
    logic have_point;
  } status_t;

  // 2048 + v/32, quotient truncated toward zero
  function automatic logic [11:0] scale_code(input logic signed [15:0] v);
    logic signed [10:0] q;
    logic [11:0]        q_ext;
    q = v[15:5];
    if (v[15] && (v[4:0] != 5'd0)) begin
      q = q + 11'sd1;
    end
    q_ext = {q[10], q};
    return q_ext + DAC_MID;
  endfunction

  function automatic logic [2:0] band_channels(input logic [7:0] colour);
    logic [2:0] rgb;
    priority if (colour <= BAND_R_MAX)  rgb = RGB_R;
    else if (colour <= BAND_RG_MAX)     rgb = RGB_RG;
    else if (colour <= BAND_G_MAX)      rgb = RGB_G;
    else if (colour <= BAND_GB_MAX)     rgb = RGB_GB;
    else if (colour <= BAND_B_MAX)      rgb = RGB_B;
    else if (colour <= BAND_BR_MAX)     rgb = RGB_BR;
    else                                rgb = RGB_WHITE;
    return rgb;
  endfunction

endpackage

@@ rtl/lpfr_ctrl.sv @@
// Controller for the laser point frame renderer: input/output handshake and sequencing.
// Depends on lpfr_pkg; drives commands into lpfr_dpath.
`timescale 1ns / 1ps

module lpfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic             item_op,
  output logic             result_valid,
  input  logic             result_stall,
  input  lpfr_pkg::status_t status,
  output lpfr_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOAD = 2'b10
  } state_t;

  state_t state, state_next;
  logic   result_valid_next;
  logic   accept;
  logic   is_tick;

  assign is_tick = (item_op == lpfr_pkg::OP_TICK);

  // a tick waits until the previous result has gone out; writes pass unless a point read is loading
  assign item_stall = (state != S_IDLE) || (result_valid && is_tick);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    cmd.wr     = accept && !is_tick;
    cmd.rd     = accept && is_tick && status.have_point;
    cmd.finish = accept && is_tick && !status.have_point;
    cmd.emit   = (state == S_LOAD);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.rd) state_next = S_LOAD;
      S_LOAD: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.finish || cmd.emit) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

@@ rtl/lpfr_dpath.sv @@
// Datapath for the laser point frame renderer: point store, slot bookkeeping,
// scaling, colour drive and result register. Depends on lpfr_pkg.
`timescale 1ns / 1ps

module lpfr_dpath (
  input  logic              clk,
  input  logic              rst,
  input  lpfr_pkg::item_t   item,
  input  lpfr_pkg::cmd_t    cmd,
  output lpfr_pkg::status_t status,
  output lpfr_pkg::result_t result
);

  localparam logic [lpfr_pkg::SLOT_W-1:0] LAST_SLOT =
    lpfr_pkg::SLOT_W'(lpfr_pkg::FRAME_SLOTS - 1);
  localparam logic [lpfr_pkg::CNT_W-1:0] CNT_MAX =
    lpfr_pkg::CNT_W'(lpfr_pkg::MAX_POINTS);

  lpfr_pkg::point_t point_store [lpfr_pkg::STORE_DEPTH];
  lpfr_pkg::point_t rd_data;

  logic [lpfr_pkg::CNT_W-1:0]  slot_point_count [lpfr_pkg::FRAME_SLOTS];
  logic [lpfr_pkg::SLOT_W-1:0] write_slot, write_slot_next;
  logic [lpfr_pkg::SLOT_W-1:0] read_slot, read_slot_next;
  logic [lpfr_pkg::CNT_W-1:0]  loaded_points, loaded_inc;
  logic [lpfr_pkg::CNT_W-1:0]  draw_index;
  logic [2:0]                  laser_drive, laser_drive_next;
  logic [lpfr_pkg::CNT_W-1:0]  cnt_sat;
  logic [lpfr_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  lpfr_pkg::point_t            wr_point;

  assign cnt_sat    = (item.frame_points > CNT_MAX) ? CNT_MAX : item.frame_points;
  assign loaded_inc = loaded_points + lpfr_pkg::CNT_W'(1);
  assign wr_addr    = {write_slot, item.point_index};
  assign rd_addr    = {read_slot, draw_index[lpfr_pkg::IDX_W-1:0]};

  assign write_slot_next = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  assign read_slot_next  = (read_slot == LAST_SLOT) ? '0 : read_slot + 1'b1;

  assign status.have_point = (draw_index < slot_point_count[read_slot]) &&
                             (draw_index < CNT_MAX);

  always_comb begin
    wr_point.x      = item.pos_x;
    wr_point.y      = item.pos_y;
    wr_point.colour = item.colour_index;
    wr_point.status = item.status_bits;
  end

  // point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr && ({1'b0, item.point_index} < CNT_MAX)) begin
      point_store[wr_addr] <= wr_point;
    end
    if (cmd.rd) begin
      rd_data <= point_store[rd_addr];
    end
  end

  always_comb begin
    laser_drive_next = laser_drive;
    if (rd_data.status[lpfr_pkg::BLANK_BIT]) begin
      laser_drive_next = lpfr_pkg::RGB_OFF;
    end else if (rd_data.colour <= lpfr_pkg::COLOUR_MAX) begin
      laser_drive_next = lpfr_pkg::band_channels(rd_data.colour);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lpfr_pkg::FRAME_SLOTS; i++) begin
        slot_point_count[i] <= '0;
      end
      write_slot    <= '0;
      loaded_points <= '0;
      read_slot     <= '0;
      draw_index    <= '0;
      laser_drive   <= lpfr_pkg::RGB_OFF;
    end else begin
      if (cmd.wr) begin
        slot_point_count[write_slot] <= cnt_sat;
        if (loaded_inc >= cnt_sat) begin
          loaded_points <= '0;
          write_slot    <= write_slot_next;
        end else begin
          loaded_points <= loaded_inc;
        end
      end
      if (cmd.finish) begin
        draw_index <= '0;
        read_slot  <= read_slot_next;
      end
      if (cmd.emit) begin
        draw_index  <= draw_index + lpfr_pkg::CNT_W'(1);
        laser_drive <= laser_drive_next;
      end
    end
  end

  // result register; held by the controller's valid until transferred
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.point_valid   <= 1'b0;
      result.dac_word_a    <= '0;
      result.dac_word_b    <= '0;
      result.laser_rgb     <= laser_drive;
      result.read_slot_out <= read_slot_next;
    end else if (cmd.emit) begin
      result.point_valid   <= 1'b1;
      result.dac_word_a    <= {lpfr_pkg::DAC_CMD_A, lpfr_pkg::scale_code(rd_data.y)};
      result.dac_word_b    <= {lpfr_pkg::DAC_CMD_B, lpfr_pkg::scale_code(rd_data.x)};
      result.laser_rgb     <= laser_drive_next;
      result.read_slot_out <= read_slot;
    end
  end

endmodule

@@ rtl/laser_point_frame_renderer_core.sv @@
// Laser point frame renderer, top level: ties controller to datapath.
// Depends on lpfr_pkg, lpfr_ctrl and lpfr_dpath.
`timescale 1ns / 1ps

// Frames are written point by point into a ring of three slots of 4096 points each
// and played back one point per tick as two DAC command words plus a colour drive.
// A write item gives no result. A tick that draws a point passes through the
// synchronous read port of the point store (address, then registered data into the
// result register); a tick that ends a frame loads the result register directly.
// A tick is held off while the previous result still waits to be transferred;
// writes go on meanwhile. The point store has no reset: only points that were
// written may be drawn.

module laser_point_frame_renderer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lpfr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output lpfr_pkg::result_t result
);

  lpfr_pkg::cmd_t    cmd;
  lpfr_pkg::status_t status;

  lpfr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_op      (item.operation),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  lpfr_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

@@ tb/sv/tb_laser_point_frame_renderer_core.sv @@
// Self-checking testbench for laser_point_frame_renderer_core: a directed table, then
// random frame traffic checked against an in-bench frame store and renderer predictor.
// Depends on lpfr_pkg and the laser_point_frame_renderer_core RTL.
`timescale 1ns / 1ps

module tb_laser_point_frame_renderer_core;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_ITEMS    = 190;
  localparam int PRESSURE_ITEMS = 40;
  localparam int BAND_SPAN      = 9;

  typedef struct {
    lpfr_pkg::item_t   stim;
    bit                typed;
    lpfr_pkg::result_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  lpfr_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  lpfr_pkg::result_t result;

  // typed-in expectation riding along with the item being offered
  logic              typed_pending;
  lpfr_pkg::result_t typed_want;

  // renderer predictor state
  lpfr_pkg::point_t pt_mem [lpfr_pkg::STORE_DEPTH];
  bit               pt_written [lpfr_pkg::STORE_DEPTH];
  int unsigned      frame_len [lpfr_pkg::FRAME_SLOTS];
  int unsigned      wr_slot;
  int unsigned      wr_loaded;
  int unsigned      rd_slot;
  int unsigned      draw_pos;
  logic [2:0]       drive_rgb;

  lpfr_pkg::result_t expected_renders [$];

  // random frame plan
  int unsigned plan_len;
  int unsigned plan_left;

  int  tick_pct;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_req;
  int  quiet_cycles;
  int  fail_count;

  laser_point_frame_renderer_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [11:0] dac_code(logic signed [15:0] v);
    int q;
    q = (int'(v) * 1024) / 32768;
    return 12'(2048 + q);
  endfunction

  // bands of nine starting at 1; 0..9 all red
  function automatic logic [2:0] band_rgb(logic [7:0] colour);
    logic [2:0] band_map [7];
    band_map = '{lpfr_pkg::RGB_R, lpfr_pkg::RGB_RG, lpfr_pkg::RGB_G, lpfr_pkg::RGB_GB,
                 lpfr_pkg::RGB_B, lpfr_pkg::RGB_BR, lpfr_pkg::RGB_WHITE};
    return band_map[(colour == 8'd0) ? 0 : (int'(colour) - 1) / BAND_SPAN];
  endfunction

  function automatic void store_point(lpfr_pkg::item_t it);
    int unsigned cnt;
    int unsigned addr;
    cnt = (it.frame_points > lpfr_pkg::MAX_POINTS) ? lpfr_pkg::MAX_POINTS : it.frame_points;
    frame_len[wr_slot] = cnt;
    addr = wr_slot * lpfr_pkg::MAX_POINTS + it.point_index;
    pt_mem[addr].x      = it.pos_x;
    pt_mem[addr].y      = it.pos_y;
    pt_mem[addr].colour = it.colour_index;
    pt_mem[addr].status = it.status_bits;
    pt_written[addr]    = 1'b1;
    wr_loaded++;
    if (wr_loaded >= cnt) begin
      wr_loaded = 0;
      wr_slot = (wr_slot + 1) % lpfr_pkg::FRAME_SLOTS;
    end
  endfunction

  function automatic lpfr_pkg::result_t render_tick();
    lpfr_pkg::result_t r;
    lpfr_pkg::point_t  p;
    r = '0;
    if (draw_pos < frame_len[rd_slot]) begin
      p = pt_mem[rd_slot * lpfr_pkg::MAX_POINTS + draw_pos];
      if (p.status[lpfr_pkg::BLANK_BIT]) begin
        drive_rgb = lpfr_pkg::RGB_OFF;
      end else if (p.colour <= lpfr_pkg::COLOUR_MAX) begin
        drive_rgb = band_rgb(p.colour);
      end
      draw_pos++;
      r.point_valid = 1'b1;
      r.dac_word_a  = {lpfr_pkg::DAC_CMD_A, dac_code(p.y)};
      r.dac_word_b  = {lpfr_pkg::DAC_CMD_B, dac_code(p.x)};
    end else begin
      draw_pos = 0;
      rd_slot = (rd_slot + 1) % lpfr_pkg::FRAME_SLOTS;
    end
    r.laser_rgb     = drive_rgb;
    r.read_slot_out = rd_slot[lpfr_pkg::SLOT_W-1:0];
    return r;
  endfunction

  // a tick must never draw a store entry that was never written
  function automatic bit tick_is_safe();
    return (draw_pos >= frame_len[rd_slot]) ||
           pt_written[rd_slot * lpfr_pkg::MAX_POINTS + draw_pos];
  endfunction

  function automatic lpfr_pkg::item_t pick_random_item();
    lpfr_pkg::item_t it;
    int unsigned     roll;
    it.operation    = lpfr_pkg::OP_WRITE;
    it.pos_x        = 16'($urandom);
    it.pos_y        = 16'($urandom);
    it.colour_index = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 70));
    it.status_bits  = 8'($urandom);
    if ($urandom_range(0, 3) != 0) it.status_bits[lpfr_pkg::BLANK_BIT] = 1'b0;
    it.point_index  = '0;
    it.frame_points = '0;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // noise: any index, any count
      it.point_index  = 12'($urandom);
      it.frame_points = 13'($urandom_range(0, 8191));
    end else if (roll < 8 + tick_pct * 92 / 100 && tick_is_safe()) begin
      it.operation = lpfr_pkg::OP_TICK;
    end else begin
      if (plan_left == 0) begin
        if ($urandom_range(0, 19) == 0) plan_len = 0;
        else if ($urandom_range(0, 9) == 0) plan_len = $urandom_range(9, 40);
        else plan_len = $urandom_range(1, 8);
        plan_left = (plan_len == 0) ? 1 : plan_len;
      end
      if (plan_len == 0) it.point_index = 12'($urandom_range(0, 15));
      else if ($urandom_range(0, 4) == 0) it.point_index = 12'($urandom_range(0, plan_len - 1));
      else it.point_index = 12'(plan_len - plan_left);
      it.frame_points = 13'(plan_len);
      plan_left--;
    end
    return it;
  endfunction

  function automatic stim_row_t write_row(logic [11:0] idx, logic [15:0] x, logic [15:0] y,
                                          logic [7:0] col, logic [7:0] st, logic [12:0] cnt);
    stim_row_t row;
    row.stim  = {lpfr_pkg::OP_WRITE, idx, x, y, col, st, cnt};
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic stim_row_t tick_row(bit typed, lpfr_pkg::result_t want);
    stim_row_t row;
    row.stim  = '0;
    row.stim.operation = lpfr_pkg::OP_TICK;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // one item per call; random items are built only after the previous transfer
  // has reached the predictor
  task automatic offer_item(bit from_table, stim_row_t row);
    lpfr_pkg::item_t it;
    @(negedge clk);
    it = from_table ? row.stim : pick_random_item();
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    item          <= it;
    item_valid    <= 1'b1;
    typed_pending <= from_table && row.typed;
    typed_want    <= row.want;
    forever begin
      @(posedge clk);
      if (item_valid && !item_stall) break;
    end
  endtask

  always @(posedge clk) begin : monitor
    lpfr_pkg::result_t want;
    bit                moved;
    if (!rst) begin
      moved = 1'b0;
      if (item_valid && !item_stall) begin
        moved = 1'b1;
        if (item.operation == lpfr_pkg::OP_TICK) begin
          want = render_tick();
          if (typed_pending) want = typed_want;
          expected_renders.push_back(want);
        end else begin
          store_point(item);
        end
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        if (expected_renders.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual 0x%0h", $time, result);
        end else begin
          want = expected_renders.pop_front();
          check_field("point_valid", want.point_valid, result.point_valid);
          check_field("dac_word_a", want.dac_word_a, result.dac_word_a);
          check_field("dac_word_b", want.dac_word_b, result.dac_word_b);
          check_field("laser_rgb", want.laser_rgb, result.laser_rgb);
          check_field("read_slot_out", want.read_slot_out, result.read_slot_out);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb_laser_point_frame_renderer_core failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t directed_rows [$];
    stim_row_t no_row;
    int        send_pcts [4];
    int        recv_pcts [4];

    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    typed_pending = 1'b0;
    typed_want    = '0;
    for (int i = 0; i < lpfr_pkg::FRAME_SLOTS; i++) frame_len[i] = 0;
    wr_slot        = 0;
    wr_loaded      = 0;
    rd_slot        = 0;
    draw_pos       = 0;
    drive_rgb      = lpfr_pkg::RGB_OFF;
    plan_len       = 0;
    plan_left      = 0;
    tick_pct       = 50;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    quiet_cycles   = 0;
    fail_count     = 0;
    no_row         = tick_row(1'b0, '0);
    send_pcts      = '{0, 61, 0, 29};
    recv_pcts      = '{0, 0, 61, 29};

    // empty store after reset: ticks only walk the slots
    directed_rows.push_back(tick_row(1'b1,
      lpfr_pkg::result_t'({1'b0, 16'h0, 16'h0, lpfr_pkg::RGB_OFF, 2'd1})));
    // coordinate extremes; colour above the last band keeps the drive
    directed_rows.push_back(write_row(12'd0, 16'h7FFF, 16'h8000, 8'd0, 8'h00, 13'd3));
    directed_rows.push_back(write_row(12'd1, 16'h8000, 16'h7FFF, 8'd63, 8'h00, 13'd3));
    directed_rows.push_back(write_row(12'd2, 16'hFFFF, 16'h0001, 8'd64, 8'h00, 13'd3));
    directed_rows.push_back(tick_row(1'b1,
      lpfr_pkg::result_t'({1'b0, 16'h0, 16'h0, lpfr_pkg::RGB_OFF, 2'd2})));
    directed_rows.push_back(tick_row(1'b1,
      lpfr_pkg::result_t'({1'b0, 16'h0, 16'h0, lpfr_pkg::RGB_OFF, 2'd0})));
    directed_rows.push_back(tick_row(1'b1,
      lpfr_pkg::result_t'({1'b1, 16'hD400, 16'h5BFF, lpfr_pkg::RGB_R, 2'd0})));
    directed_rows.push_back(tick_row(1'b1,
      lpfr_pkg::result_t'({1'b1, 16'hDBFF, 16'h5400, lpfr_pkg::RGB_WHITE, 2'd0})));
    directed_rows.push_back(tick_row(1'b1,
      lpfr_pkg::result_t'({1'b1, 16'hD800, 16'h5800, lpfr_pkg::RGB_WHITE, 2'd0})));
    directed_rows.push_back(tick_row(1'b1,
      lpfr_pkg::result_t'({1'b0, 16'h0, 16'h0, lpfr_pkg::RGB_WHITE, 2'd1})));
    // oversized count, blanked point, zero-count frame at the top index
    directed_rows.push_back(write_row(12'd0, 16'h0064, 16'hFF9C, 8'd30, 8'h40, 13'd8191));
    directed_rows.push_back(write_row(12'd1, 16'h1234, 16'hEDCB, 8'd40, 8'hBF, 13'd2));
    directed_rows.push_back(write_row(12'd4095, 16'hFFE0, 16'h001F, 8'd255, 8'hFF, 13'd0));
    directed_rows.push_back(tick_row(1'b0, '0));
    directed_rows.push_back(tick_row(1'b0, '0));
    directed_rows.push_back(tick_row(1'b1,
      lpfr_pkg::result_t'({1'b0, 16'h0, 16'h0, lpfr_pkg::RGB_B, 2'd2})));
    directed_rows.push_back(tick_row(1'b1,
      lpfr_pkg::result_t'({1'b0, 16'h0, 16'h0, lpfr_pkg::RGB_B, 2'd0})));
    // band edges
    directed_rows.push_back(write_row(12'd0, 16'hFFDF, 16'hFFE0, 8'd10, 8'h00, 13'd4));
    directed_rows.push_back(write_row(12'd1, 16'h0021, 16'h001F, 8'd27, 8'h3F, 13'd4));
    directed_rows.push_back(write_row(12'd2, 16'hAAAA, 16'h5555, 8'd36, 8'h00, 13'd4));
    directed_rows.push_back(write_row(12'd3, 16'h5555, 16'hAAAA, 8'd46, 8'h80, 13'd4));
    repeat (4) directed_rows.push_back(tick_row(1'b0, '0));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) offer_item(1'b1, directed_rows[i]);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      repeat (PHASE_ITEMS) offer_item(1'b0, no_row);
    end

    // long receiver hold-off with mostly ticks on offer, so the core backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    tick_pct       = 90;
    hold_req       = 1'b1;
    repeat (PRESSURE_ITEMS) offer_item(1'b0, no_row);

    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_renders.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_laser_point_frame_renderer_core passed");
    end else begin
      $display("tb_laser_point_frame_renderer_core failed");
    end
    $finish;
  end

endmodule
